[hdl/rcv_pkg.sv]
// ---------------------------------------------------------------------------
// rcv_pkg
// shared types and codes for the redundant channel voter
// ---------------------------------------------------------------------------
package rcv_pkg;

  // request codes
  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_VOTE   = 2'd1;
  localparam logic [1:0] REQ_XCHECK = 2'd2;
  localparam logic [1:0] REQ_HEALTH = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANGE    = 2'd1;
  localparam logic [1:0] ST_NO_ELIG  = 2'd2;

  // vote modes (any other code votes by average)
  localparam logic [1:0] MODE_MEDIAN = 2'd0;
  localparam logic [1:0] MODE_FIRST  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_COUNT     = 2'd0;
  localparam logic [1:0] CFG_MODE      = 2'd1;
  localparam logic [1:0] CFG_THRESHOLD = 2'd2;

  localparam logic [3:0]  COUNT_RST     = 4'd3;
  localparam logic [1:0]  MODE_RST      = 2'd0;
  localparam logic [30:0] THRESHOLD_RST = 31'd65536;

  localparam logic [4:0] MISM_MAX = 5'd31;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] voted_value;
    logic [3:0]  eligible_count;
    logic [7:0]  failed_mask;
    logic        consensus;
    logic [8:0]  confidence;
    logic [4:0]  mismatch_count;
    logic [3:0]  healthy_count;
    logic        health_quorum;
    logic        degraded;
    logic [31:0] vote_total;
    logic [31:0] disagreement_total;
  } result_t;

endpackage

[hdl/redundant_channel_voter.sv]
// ---------------------------------------------------------------------------
// redundant_channel_voter
// per-channel readings with valid and health flags; vote by upper median,
// average or first eligible, pairwise cross-check and health summary
// ---------------------------------------------------------------------------
//  channel | signals                                  | direction
//  input   | in_valid_i, in_stall_o, req fields       | request in
//  output  | out_valid_o, out_stall_i, result fields  | one result out
//  config  | cfg_valid_i, cfg_ready_o, index, data    | register write
//
//  write and set health go straight from idle to the done step.
//  median vote: a compare pass per candidate plus a consensus pass plus a
//  divider pass for confidence; average: a sum pass, two
//  divider passes and a consensus pass; cross-check scans each channel pair once.
//  one shared signed compare unit and a bit-serial divider do this work.
//  reset clears the reading flags, counters and stored readings and sets all system health flags; no clearing pass.
//  the next request is taken while a finished result waits on out_stall_i.
module redundant_channel_voter #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [2:0]         channel_i,
  input  logic signed [31:0] sample_value_i,
  input  logic               sample_valid_i,
  input  logic               sample_healthy_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] voted_value_o,
  output logic [3:0]         eligible_count_o,
  output logic [7:0]         failed_mask_o,
  output logic               consensus_o,
  output logic [8:0]         confidence_o,
  output logic [4:0]         mismatch_count_o,
  output logic [3:0]         healthy_count_o,
  output logic               health_quorum_o,
  output logic               degraded_o,
  output logic [31:0]        vote_total_o,
  output logic [31:0]        disagreement_total_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int CW = $clog2(MAX_CHANNELS);
  localparam int NW = $clog2(MAX_CHANNELS + 1);
  localparam int SW = 33 + $clog2(MAX_CHANNELS);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CAND = 7'b0000010,
    S_SCAN = 7'b0000100,
    S_SUM  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_CONS = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [3:0]  count_q;
  logic [1:0]  mode_q;
  logic [30:0] thr_q;

  logic signed [31:0] val_q [MAX_CHANNELS];
  logic signed [31:0] val_d [MAX_CHANNELS];
  logic [MAX_CHANNELS-1:0] vld_q, vld_d;
  logic [MAX_CHANNELS-1:0] dh_q, dh_d;
  logic [MAX_CHANNELS-1:0] sh_q, sh_d;
  logic [31:0] votes_q, votes_d;
  logic [31:0] disagree_q, disagree_d;

  logic [1:0]              req_q, req_d;
  logic [MAX_CHANNELS-1:0] elig_q, elig_d;
  logic [NW-1:0]           cnt_q, cnt_d;
  logic [CW-1:0]           k_q, k_d;
  logic [CW-1:0]           j_q, j_d;
  logic signed [31:0]      cand_q, cand_d;
  logic [NW-1:0]           lt_q, lt_d;
  logic [NW-1:0]           le_q, le_d;
  logic [SW-1:0]           sum_q, sum_d;
  logic                    cons_q, cons_d;
  logic [4:0]              mism_q, mism_d;
  logic                    div_conf_q, div_conf_d;
  logic                    neg_q, neg_d;
  rcv_pkg::result_t        res_q, res_d;
  rcv_pkg::result_t        out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  // combinational helpers
  logic [NW-1:0]           n_use;
  logic [MAX_CHANNELS-1:0] elig_now;
  logic [MAX_CHANNELS-1:0] fail_now;
  logic [NW-1:0]           elig_cnt;
  logic [NW-1:0]           h_cnt;
  logic                    ch_ok;
  logic [CW-1:0]           ch_idx;
  logic [CW-1:0]           rd_idx;
  logic signed [31:0]      rd_val;
  logic [32:0]             diff;
  logic [32:0]             mag;
  logic                    less;
  logic                    zero;
  logic                    beyond;
  logic                    last_j;
  logic [NW-1:0]           lt_n, le_n;
  logic [SW-1:0]           sum_n;
  logic                    cons_n;
  logic [31:0]             avg_val;
  logic                    out_fire;

  logic                   div_start;
  logic [SW-1:0]          div_dividend;
  logic [NW-1:0]          div_divisor;
  rcv_pkg::div_stat_t     div_stat;
  logic [SW-1:0]          div_quot;

  rcv_divider #(
    .DW (SW),
    .VW (NW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  // configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= rcv_pkg::COUNT_RST;
      mode_q  <= rcv_pkg::MODE_RST;
      thr_q   <= rcv_pkg::THRESHOLD_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        rcv_pkg::CFG_COUNT:     count_q <= cfg_data_i[3:0];
        rcv_pkg::CFG_MODE:      mode_q  <= cfg_data_i[1:0];
        rcv_pkg::CFG_THRESHOLD: thr_q   <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // channel count saturated into the supported range
  always_comb begin
    if (count_q < 4'd2) begin
      n_use = NW'(2);
    end else if (int'(count_q) > MAX_CHANNELS) begin
      n_use = NW'(MAX_CHANNELS);
    end else begin
      n_use = NW'(count_q);
    end
  end

  always_comb begin
    elig_cnt = '0;
    for (int i = 0; i < MAX_CHANNELS; i++) begin
      elig_now[i] = vld_q[i] && dh_q[i] && (i < int'(n_use));
      fail_now[i] = !elig_now[i] && (i < int'(n_use));
      elig_cnt    = elig_cnt + NW'(elig_now[i]);
    end
  end

  assign ch_ok  = int'(channel_i) < int'(n_use);
  assign ch_idx = CW'(channel_i);

  // shared compare unit: stored reading against the held candidate
  assign rd_idx = (state_q == S_CAND) ? k_q : j_q;
  assign rd_val = val_q[rd_idx];
  assign diff   = {rd_val[31], rd_val} - {cand_q[31], cand_q};
  assign less   = diff[32];
  assign zero   = (diff == '0);
  assign mag    = less ? (~diff + 33'd1) : diff;
  assign beyond = mag > {2'b00, thr_q};
  assign last_j = (NW'(j_q) + NW'(1)) == n_use;

  assign lt_n  = lt_q + NW'(elig_q[j_q] && less);
  assign le_n  = le_q + NW'(elig_q[j_q] && (less || zero));
  assign sum_n = elig_q[j_q] ? (sum_q + {{(SW-32){rd_val[31]}}, rd_val}) : sum_q;
  assign cons_n = cons_q && !(elig_q[j_q] && beyond);
  assign avg_val = neg_q ? (~div_quot[31:0] + 32'd1) : div_quot[31:0];

  assign out_fire = out_valid_q && !out_stall_i;

  always_comb begin
    state_d     = state_q;
    val_d       = val_q;
    vld_d       = vld_q;
    dh_d        = dh_q;
    sh_d        = sh_q;
    votes_d     = votes_q;
    disagree_d  = disagree_q;
    req_d       = req_q;
    elig_d      = elig_q;
    cnt_d       = cnt_q;
    k_d         = k_q;
    j_d         = j_q;
    cand_d      = cand_q;
    lt_d        = lt_q;
    le_d        = le_q;
    sum_d       = sum_q;
    cons_d      = cons_q;
    mism_d      = mism_q;
    div_conf_d  = div_conf_q;
    neg_d       = neg_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_fire;
    div_start    = 1'b0;
    div_dividend = SW'({cnt_q, 8'b0});
    div_divisor  = n_use;
    h_cnt        = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '0;
          req_d   = req_type_i;
          state_d = S_DONE;
          unique case (req_type_i)
            rcv_pkg::REQ_WRITE: begin
              if (ch_ok) begin
                val_d[ch_idx] = sample_value_i;
                vld_d[ch_idx] = sample_valid_i;
                dh_d[ch_idx]  = sample_healthy_i;
              end else begin
                res_d.status = rcv_pkg::ST_RANGE;
              end
            end
            rcv_pkg::REQ_HEALTH: begin
              if (ch_ok) begin
                sh_d[ch_idx] = sample_healthy_i;
                for (int i = 0; i < MAX_CHANNELS; i++) begin
                  h_cnt = h_cnt + NW'(sh_d[i] && (i < int'(n_use)));
                end
                res_d.healthy_count = 4'(h_cnt);
                res_d.health_quorum = h_cnt >= NW'(2);
                res_d.degraded      = h_cnt < n_use;
              end else begin
                res_d.status = rcv_pkg::ST_RANGE;
              end
            end
            rcv_pkg::REQ_VOTE: begin
              votes_d              = votes_q + 32'd1;
              elig_d               = elig_now;
              cnt_d                = elig_cnt;
              res_d.eligible_count = 4'(elig_cnt);
              res_d.failed_mask    = 8'(fail_now);
              k_d                  = '0;
              j_d                  = '0;
              sum_d                = '0;
              if (elig_cnt == '0) begin
                res_d.status = rcv_pkg::ST_NO_ELIG;
              end else if (mode_q == rcv_pkg::MODE_MEDIAN ||
                           mode_q == rcv_pkg::MODE_FIRST) begin
                state_d = S_CAND;
              end else begin
                state_d = S_SUM;
              end
            end
            rcv_pkg::REQ_XCHECK: begin
              k_d     = '0;
              mism_d  = '0;
              state_d = S_CAND;
            end
            default: ;
          endcase
        end
      end

      S_CAND: begin
        if (req_q == rcv_pkg::REQ_XCHECK) begin
          if ((NW'(k_q) + NW'(1)) >= n_use) begin
            res_d.mismatch_count = mism_q;
            state_d              = S_DONE;
          end else if (!vld_q[k_q]) begin
            k_d = k_q + CW'(1);
          end else begin
            cand_d  = rd_val;
            j_d     = k_q + CW'(1);
            state_d = S_SCAN;
          end
        end else if (!elig_q[k_q]) begin
          k_d = k_q + CW'(1);
        end else begin
          cand_d = rd_val;
          j_d    = '0;
          lt_d   = '0;
          le_d   = '0;
          cons_d = 1'b1;
          if (mode_q == rcv_pkg::MODE_FIRST) begin
            state_d = S_CONS;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        j_d = j_q + CW'(1);
        if (req_q == rcv_pkg::REQ_XCHECK) begin
          if (vld_q[j_q] && beyond && mism_q != rcv_pkg::MISM_MAX) begin
            mism_d = mism_q + 5'd1;
          end
          if (last_j) begin
            k_d     = k_q + CW'(1);
            state_d = S_CAND;
          end
        end else begin
          lt_d = lt_n;
          le_d = le_n;
          if (last_j) begin
            // candidate is the upper median when its rank range covers cnt/2
            if (lt_n <= (cnt_q >> 1) && le_n > (cnt_q >> 1)) begin
              j_d     = '0;
              cons_d  = 1'b1;
              state_d = S_CONS;
            end else begin
              k_d     = k_q + CW'(1);
              state_d = S_CAND;
            end
          end
        end
      end

      S_SUM: begin
        sum_d = sum_n;
        j_d   = j_q + CW'(1);
        if (last_j) begin
          neg_d        = sum_n[SW-1];
          div_dividend = sum_n[SW-1] ? (~sum_n + SW'(1)) : sum_n;
          div_divisor  = cnt_q;
          div_start    = 1'b1;
          div_conf_d   = 1'b0;
          state_d      = S_DIV;
        end
      end

      S_DIV: begin
        if (div_stat.done) begin
          if (div_conf_q) begin
            res_d.confidence = 9'(div_quot);
            state_d          = S_DONE;
          end else begin
            cand_d  = avg_val;
            j_d     = '0;
            cons_d  = 1'b1;
            state_d = S_CONS;
          end
        end
      end

      S_CONS: begin
        cons_d = cons_n;
        j_d    = j_q + CW'(1);
        if (last_j) begin
          res_d.voted_value = cand_q;
          res_d.consensus   = cons_n;
          if (!cons_n) begin
            disagree_d = disagree_q + 32'd1;
          end
          // confidence = eligible * 256 / count in use
          div_dividend = SW'({cnt_q, 8'b0});
          div_divisor  = n_use;
          div_start    = 1'b1;
          div_conf_d   = 1'b1;
          state_d      = S_DIV;
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_fire) begin
          out_d                    = res_q;
          out_d.vote_total         = votes_q;
          out_d.disagreement_total = disagree_q;
          out_valid_d              = 1'b1;
          state_d                  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      dh_q        <= '0;
      sh_q        <= '1;
      votes_q     <= '0;
      disagree_q  <= '0;
      out_valid_q <= 1'b0;
      req_q       <= rcv_pkg::REQ_WRITE;
      div_conf_q  <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        val_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      vld_q       <= vld_d;
      dh_q        <= dh_d;
      sh_q        <= sh_d;
      votes_q     <= votes_d;
      disagree_q  <= disagree_d;
      out_valid_q <= out_valid_d;
      req_q       <= req_d;
      div_conf_q  <= div_conf_d;
      val_q       <= val_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elig_q <= elig_d;
    cnt_q  <= cnt_d;
    k_q    <= k_d;
    j_q    <= j_d;
    cand_q <= cand_d;
    lt_q   <= lt_d;
    le_q   <= le_d;
    sum_q  <= sum_d;
    cons_q <= cons_d;
    mism_q <= mism_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign in_stall_o           = (state_q != S_IDLE);
  assign out_valid_o          = out_valid_q;
  assign status_o             = out_q.status;
  assign voted_value_o        = out_q.voted_value;
  assign eligible_count_o     = out_q.eligible_count;
  assign failed_mask_o        = out_q.failed_mask;
  assign consensus_o          = out_q.consensus;
  assign confidence_o         = out_q.confidence;
  assign mismatch_count_o     = out_q.mismatch_count;
  assign healthy_count_o      = out_q.healthy_count;
  assign health_quorum_o      = out_q.health_quorum;
  assign degraded_o           = out_q.degraded;
  assign vote_total_o         = out_q.vote_total;
  assign disagreement_total_o = out_q.disagreement_total;

  a_vote_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) && in_valid_i && req_type_i == rcv_pkg::REQ_VOTE
      |=> votes_q == $past(votes_q) + 32'd1)
    else $error("vote transaction not counted");

  a_rank_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && req_q == rcv_pkg::REQ_VOTE |-> lt_q <= le_q)
    else $error("median rank counts out of order");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result shown outside the done step");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy && state_q != S_DIV)
    else $error("divider restarted during a division");

endmodule

[hdl/rcv_divider.sv]
// ---------------------------------------------------------------------------
// rcv_divider
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module rcv_divider #(
  parameter int DW = 36,
  parameter int VW = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DW-1:0]       dividend_i,
  input  logic [VW-1:0]       divisor_i,
  output rcv_pkg::div_stat_t  stat_o,
  output logic [DW-1:0]       quot_o
);

  localparam int CTW = $clog2(DW + 1);

  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [CTW-1:0] cnt_q, cnt_d;
  logic [DW-1:0]  quo_q, quo_d;
  logic [VW-1:0]  rem_q, rem_d;
  logic [VW-1:0]  dvs_q, dvs_d;

  logic [VW:0] trial;
  logic [VW:0] trial_sub;
  logic        ge;

  assign trial     = {rem_q, quo_q[DW-1]};
  assign ge        = trial >= {1'b0, dvs_q};
  assign trial_sub = trial - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CTW'(DW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits in VW bits
      rem_d = ge ? trial_sub[VW-1:0] : trial[VW-1:0];
      quo_d = {quo_q[DW-2:0], ge};
      cnt_d = cnt_q - CTW'(1);
      if (cnt_q == CTW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quot_o      = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while still busy");

  a_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> (cnt_q == $past(cnt_q) - CTW'(1)))
    else $error("divider step count did not advance");

endmodule

[tb/redundant_channel_voter_test.sv]
// ---------------------------------------------------------------------------
// redundant_channel_voter_test
// drives write, vote, cross-check and set-health requests through the voter
// under random idling on both sides, predicts every result from a local model
// of the channel store and counters, and compares each output transaction
// field by field across several register settings
// ---------------------------------------------------------------------------
module redundant_channel_voter_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         channel;
    logic signed [31:0] sample_value;
    logic               sample_valid;
    logic               sample_healthy;
  } request_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o;
  logic [1:0] req_type_i;
  logic [2:0] channel_i;
  logic signed [31:0] sample_value_i;
  logic sample_valid_i, sample_healthy_i;
  logic out_valid_o, out_stall_i;
  logic [1:0] status_o;
  logic signed [31:0] voted_value_o;
  logic [3:0] eligible_count_o;
  logic [7:0] failed_mask_o;
  logic consensus_o;
  logic [8:0] confidence_o;
  logic [4:0] mismatch_count_o;
  logic [3:0] healthy_count_o;
  logic health_quorum_o, degraded_o;
  logic [31:0] vote_total_o, disagreement_total_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  redundant_channel_voter DUT (.*);

  // predictor state
  logic [3:0]         m_count;
  logic [1:0]         m_mode;
  logic [30:0]        m_thresh;
  logic signed [31:0] m_value [8];
  logic [7:0]         m_valid, m_dhealthy, m_shealthy;
  logic [31:0]        m_votes, m_disagree;

  request_t pending_reqs[$];
  rcv_pkg::result_t expected_results[$];
  int errors = 0;
  bit quiet = 0;          // no idling toward the end
  bit hold_sender = 0;
  bit hold_receiver = 0;
  int in_gap = 0, out_gap = 0;
  int idle_cycles = 0;

  initial begin
    clk_i = 0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic out_of_band(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return d > longint'(m_thresh);
  endfunction

  function automatic int used_channels();
    if (m_count < 2) return 2;
    if (m_count > 8) return 8;
    return m_count;
  endfunction

  function automatic rcv_pkg::result_t predict_result(request_t r);
    rcv_pkg::result_t   e;
    int                 n, cnt, h, k, j, mism;
    logic signed [31:0] vals[8];
    logic signed [31:0] key, res;
    longint             sum;
    logic               cons;
    e = '0;
    n = used_channels();
    cnt = 0;
    case (r.req_type)
      rcv_pkg::REQ_WRITE: begin
        if (r.channel >= n) e.status = rcv_pkg::ST_RANGE;
        else begin
          m_value[r.channel] = r.sample_value;
          m_valid[r.channel] = r.sample_valid;
          m_dhealthy[r.channel] = r.sample_healthy;
        end
      end
      rcv_pkg::REQ_VOTE: begin
        for (k = 0; k < n; k++)
          if (m_valid[k] && m_dhealthy[k]) begin
            vals[cnt] = m_value[k];
            cnt++;
          end else e.failed_mask[k] = 1'b1;
        m_votes++;
        e.eligible_count = 4'(cnt);
        if (cnt == 0) e.status = rcv_pkg::ST_NO_ELIG;
        else begin
          if (m_mode == rcv_pkg::MODE_FIRST) res = vals[0];
          else if (m_mode == rcv_pkg::MODE_MEDIAN) begin
            logic signed [31:0] srt[8];
            for (k = 0; k < cnt; k++) srt[k] = vals[k];
            for (k = 1; k < cnt; k++) begin
              key = srt[k];
              j = k;
              while (j > 0 && srt[j-1] > key) begin
                srt[j] = srt[j-1];
                j--;
              end
              srt[j] = key;
            end
            res = srt[cnt/2];
          end else begin
            sum = 0;
            for (k = 0; k < cnt; k++) sum += longint'(vals[k]);
            res = 32'(sum / cnt);
          end
          cons = 1'b1;
          for (k = 0; k < cnt; k++) if (out_of_band(vals[k], res)) cons = 1'b0;
          if (!cons) m_disagree++;
          e.voted_value = res;
          e.consensus = cons;
          e.confidence = 9'((cnt * 256) / n);
        end
      end
      rcv_pkg::REQ_XCHECK: begin
        mism = 0;
        for (k = 0; k < n - 1; k++)
          for (j = k + 1; j < n; j++)
            if (m_valid[k] && m_valid[j] && out_of_band(m_value[k], m_value[j])) mism++;
        e.mismatch_count = (mism > 31) ? rcv_pkg::MISM_MAX : 5'(mism);
      end
      default: begin
        if (r.channel >= n) e.status = rcv_pkg::ST_RANGE;
        else begin
          m_shealthy[r.channel] = r.sample_healthy;
          h = 0;
          for (k = 0; k < n; k++) if (m_shealthy[k]) h++;
          e.healthy_count = 4'(h);
          e.health_quorum = h >= 2;
          e.degraded = h < n;
        end
      end
    endcase
    e.vote_total = m_votes;
    e.disagreement_total = m_disagree;
    return e;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // sender: each accepted transaction is predicted at the accepting edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= '0;
      channel_i <= '0;
      sample_value_i <= '0;
      sample_valid_i <= 1'b0;
      sample_healthy_i <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(predict_result(pending_reqs.pop_front()));
      if (in_valid_i && in_stall_o) begin
        // hold payload
      end else if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        in_gap <= $urandom_range(1, 15);
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() > 0 && !hold_sender) begin
        in_valid_i <= 1'b1;
        req_type_i <= pending_reqs[0].req_type;
        channel_i <= pending_reqs[0].channel;
        sample_value_i <= pending_reqs[0].sample_value;
        sample_valid_i <= pending_reqs[0].sample_valid;
        sample_healthy_i <= pending_reqs[0].sample_healthy;
      end else in_valid_i <= 1'b0;
    end
  end

  // receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    rcv_pkg::result_t e;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("unexpected result transaction at %0t", $realtime);
          errors++;
        end else begin
          e = expected_results.pop_front();
          if (status_o !== e.status)
            report_mismatch("status", 32'(status_o), 32'(e.status));
          if (voted_value_o !== e.voted_value)
            report_mismatch("voted_value", voted_value_o, e.voted_value);
          if (eligible_count_o !== e.eligible_count)
            report_mismatch("eligible_count", 32'(eligible_count_o), 32'(e.eligible_count));
          if (failed_mask_o !== e.failed_mask)
            report_mismatch("failed_mask", 32'(failed_mask_o), 32'(e.failed_mask));
          if (consensus_o !== e.consensus)
            report_mismatch("consensus", 32'(consensus_o), 32'(e.consensus));
          if (confidence_o !== e.confidence)
            report_mismatch("confidence", 32'(confidence_o), 32'(e.confidence));
          if (mismatch_count_o !== e.mismatch_count)
            report_mismatch("mismatch_count", 32'(mismatch_count_o), 32'(e.mismatch_count));
          if (healthy_count_o !== e.healthy_count)
            report_mismatch("healthy_count", 32'(healthy_count_o), 32'(e.healthy_count));
          if (health_quorum_o !== e.health_quorum)
            report_mismatch("health_quorum", 32'(health_quorum_o), 32'(e.health_quorum));
          if (degraded_o !== e.degraded)
            report_mismatch("degraded", 32'(degraded_o), 32'(e.degraded));
          if (vote_total_o !== e.vote_total)
            report_mismatch("vote_total", vote_total_o, e.vote_total);
          if (disagreement_total_o !== e.disagreement_total)
            report_mismatch("disagreement_total", disagreement_total_o, e.disagreement_total);
        end
      end
      if (hold_receiver) out_stall_i <= 1'b1;
      else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 19) == 0) begin
        out_gap <= $urandom_range(1, 15);
        out_stall_i <= 1'b1;
      end else out_stall_i <= 1'b0;
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || hold_receiver)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("redundant_channel_voter regression: fail");
      $finish;
    end
  end

  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      rcv_pkg::CFG_COUNT: m_count = data[3:0];
      rcv_pkg::CFG_MODE:  m_mode = data[1:0];
      default:            m_thresh = data[30:0];
    endcase
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  function automatic request_t make_req(logic [1:0] t, logic [2:0] ch, logic [31:0] v,
                                        logic vl, logic hl);
    request_t r;
    r.req_type = t;
    r.channel = ch;
    r.sample_value = v;
    r.sample_valid = vl;
    r.sample_healthy = hl;
    return r;
  endfunction

  // random value: mostly clustered near a center so consensus can hold
  function automatic logic [31:0] pick_value(logic [31:0] center);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return center + $urandom_range(0, 200000) - 100000;
    endcase
  endfunction

  task automatic queue_random(int items);
    logic [31:0] center;
    int k, n;
    center = $urandom();
    n = used_channels();
    for (k = 0; k < items; k++) begin
      if ($urandom_range(0, 9) == 0) center = $urandom();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE,
                        ($urandom_range(0, 7) == 0) ? 3'($urandom()) :
                        3'($urandom_range(0, n - 1)),
                        pick_value(center), $urandom_range(0, 4) != 0,
                        $urandom_range(0, 4) != 0));
        4, 5, 6: pending_reqs.push_back(make_req(rcv_pkg::REQ_VOTE, 3'($urandom()),
                        $urandom(), 1'($urandom()), 1'($urandom())));
        7: pending_reqs.push_back(make_req(rcv_pkg::REQ_XCHECK, 3'($urandom()),
                        $urandom(), 1'($urandom()), 1'($urandom())));
        default: pending_reqs.push_back(make_req(rcv_pkg::REQ_HEALTH, 3'($urandom()),
                        $urandom(), 1'($urandom()), $urandom_range(0, 3) != 0));
      endcase
    end
  endtask

  initial begin
    int ph, k;
    logic [31:0] thr;
    cfg_valid_i = 0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    m_count = rcv_pkg::COUNT_RST;
    m_mode = rcv_pkg::MODE_RST;
    m_thresh = rcv_pkg::THRESHOLD_RST;
    for (k = 0; k < 8; k++) m_value[k] = '0;
    m_valid = '0;
    m_dhealthy = '0;
    m_shealthy = '1;
    m_votes = '0;
    m_disagree = '0;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1;

    // directed: vote with nothing eligible, range errors, extremes, median ties
    pending_reqs.push_back(make_req(rcv_pkg::REQ_VOTE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_XCHECK, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 7, 32'h12345678, 1, 1));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_HEALTH, 5, 0, 0, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 0, 32'h7fffffff, 1, 1));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 1, 32'h80000000, 1, 1));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 2, 32'h7fffffff, 1, 1));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_VOTE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_XCHECK, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 2, 32'hffffffff, 1, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_VOTE, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_HEALTH, 0, 0, 0, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_HEALTH, 1, 0, 0, 0));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_HEALTH, 1, 0, 0, 1));
    wait_drained();
    // average with mixed signs to exercise truncation toward zero
    write_register(rcv_pkg::CFG_MODE, 1);
    pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 0, -7, 1, 1));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 1, 2, 1, 1));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 2, 0, 1, 1));
    pending_reqs.push_back(make_req(rcv_pkg::REQ_VOTE, 0, 0, 0, 0));
    wait_drained();
    write_register(rcv_pkg::CFG_MODE, 3);
    pending_reqs.push_back(make_req(rcv_pkg::REQ_VOTE, 0, 0, 0, 0));
    wait_drained();
    // sweep register settings with random traffic
    for (ph = 0; ph < 12; ph++) begin
      write_register(rcv_pkg::CFG_COUNT, (ph == 0) ? 0 : (ph == 1) ? 15 : (ph == 2) ? 8 :
                     (ph == 3) ? 2 : $urandom_range(0, 15));
      write_register(rcv_pkg::CFG_MODE, ph % 4);
      case (ph % 4)
        0: thr = 0;
        1: thr = 32'h7fffffff;
        default: thr = $urandom_range(0, 300000);
      endcase
      write_register(rcv_pkg::CFG_THRESHOLD, (ph == 5) ? 32'hffffffff : thr);
      // fill all channels with alternating extremes so many pairs mismatch
      if (ph == 2)
        for (k = 0; k < 8; k++)
          pending_reqs.push_back(make_req(rcv_pkg::REQ_WRITE, 3'(k),
                                          (k % 2) ? 32'h7fffffff : 32'h80000000, 1, 1));
      if (ph == 10) quiet = 1;
      queue_random(100);
      if (ph == 4) begin
        // receiver holds off long while the sender keeps offering
        hold_receiver = 1;
        repeat (3000) @(posedge clk_i);
        hold_receiver = 0;
      end
      if (ph == 6) begin
        // let traffic get going, then the sender pauses until all results are back
        repeat (200) @(posedge clk_i);
        hold_sender = 1;
        while (expected_results.size() > 0) @(posedge clk_i);
        hold_sender = 0;
      end
      wait_drained();
    end

    if (errors == 0) $display("redundant_channel_voter regression: pass");
    else $display("redundant_channel_voter regression: fail");
    $finish;
  end
endmodule
